// ===== hdl/fixed_chunk_pool_allocator_defines.svh =====
// assertion macros used by the chunk pool allocator datapath
`ifndef FIXED_CHUNK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_CHUNK_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FCPA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FCPA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fcpa_pkg.sv =====
// shared types and constants of the chunk pool allocator
package fcpa_pkg;

  // pool size default and the cap on the reset total
  localparam int unsigned DEF_MAX_CHUNKS  = 1024;
  localparam int unsigned RESET_TOTAL_CAP = 1024;

  // field widths
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned TOTAL_W  = 11;
  localparam int unsigned RUN_W    = 11;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned STATUS_W = 2;

  // reciprocals for ceil(t/10) and ceil(t/20), exact for t below 2048
  localparam int unsigned DIV10_MUL = 6554;
  localparam int unsigned DIV20_MUL = 3277;
  localparam int unsigned DIV_SHIFT = 16;
  localparam int unsigned PROD_W    = 24;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_FETCH,
    S_DONE
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic exec;
    logic push;
    logic fetch;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic go_push;
    logic go_fetch;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/fcpa_ctrl.sv =====
// sequencing state machine of the chunk pool allocator
module fcpa_ctrl import fcpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          if (stat_i.go_push) begin
            state_d = S_PUSH;
          end else if (stat_i.go_fetch) begin
            state_d = S_FETCH;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_DONE;
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/fcpa_datapath.sv =====
// free list storage, head registers, counters and result register
`include "fixed_chunk_pool_allocator_defines.svh"

module fcpa_datapath import fcpa_pkg::*; #(
  parameter int unsigned MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TOTAL_W-1:0] cfg_wdata_i,
  input  logic               in_opcode_i,
  input  logic [IDX_W-1:0]   in_chunk_index_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [IDX_W-1:0]   out_granted_index_o,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [CNT_W-1:0]   out_free_count_o,
  output logic [TOTAL_W-1:0] out_danger_excess_o,
  input  cmd_t               cmd_i,
  output stat_t              stat_o
);

  localparam int unsigned IW = $clog2(MAX_CHUNKS);
  localparam int unsigned LW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned EW = RUN_W + LW;
  localparam int unsigned RESET_TOTAL =
    (MAX_CHUNKS < RESET_TOTAL_CAP) ? MAX_CHUNKS : RESET_TOTAL_CAP;
  localparam logic [TOTAL_W-1:0] RESET_THR95 = TOTAL_W'(RESET_TOTAL * 95 / 100);
  localparam logic [TOTAL_W-1:0] RESET_THR90 = TOTAL_W'(RESET_TOTAL * 90 / 100);
  localparam logic [LW-1:0] NO_LINK = LW'(MAX_CHUNKS);

  // entry memory: {run length, link}
  logic [EW-1:0] entry_mem_q [MAX_CHUNKS];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [EW-1:0] mem_wdata;

  // pool state
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [TOTAL_W-1:0] thr95_q, thr90_q;
  logic [LW-1:0]      head_q, head_d;
  logic [RUN_W-1:0]   head_run_q, head_run_d;
  logic [LW-1:0]      head_link_q, head_link_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]      idx_q;

  // pending result and output register
  logic [IDX_W-1:0]   res_granted_q, res_granted_d;
  status_e            res_status_q, res_status_d;
  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   out_granted_q;
  status_e            out_status_q;
  logic [CNT_W-1:0]   out_cnt_q;
  logic [TOTAL_W-1:0] out_danger_q;

  // decode of the offered operation
  logic          is_free;
  logic          head_valid;
  logic          link_valid;
  logic          alloc_empty;
  logic          run_multi;
  logic          free_ok;
  logic [IW-1:0] head_addr;
  logic [IW-1:0] next_addr;
  logic [TOTAL_W-1:0] cfg_total;

  // thresholds and danger excess
  logic [TOTAL_W:0]   t_p19, t_p9;
  logic [PROD_W-1:0]  prod20, prod10;
  logic [TOTAL_W-1:0] ceil20, ceil10;
  logic [TOTAL_W-1:0] used;
  logic [TOTAL_W-1:0] danger;

  assign is_free     = (in_opcode_i == OP_FREE);
  assign head_valid  = (head_q < NO_LINK);
  assign link_valid  = (head_link_q < NO_LINK);
  assign alloc_empty = (cnt_q == '0) || !head_valid;
  assign run_multi   = (head_run_q > RUN_W'(1));
  assign free_ok     = ({1'b0, in_chunk_index_i} < total_q)
                    && (32'(in_chunk_index_i) < 32'(MAX_CHUNKS));
  assign head_addr   = head_q[IW-1:0];
  assign next_addr   = (32'(head_addr) == 32'(MAX_CHUNKS - 1)) ? '0 : head_addr + IW'(1);

  assign stat_o.go_push  = is_free && free_ok;
  assign stat_o.go_fetch = !is_free && !alloc_empty && !run_multi && link_valid;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // written total clamped into 1..MAX_CHUNKS
  always_comb begin
    cfg_total = cfg_wdata_i;
    if (cfg_total == '0) begin
      cfg_total = TOTAL_W'(1);
    end else if (32'(cfg_total) > 32'(MAX_CHUNKS)) begin
      cfg_total = TOTAL_W'(MAX_CHUNKS);
    end
  end

  // ceil(t/20) and ceil(t/10) by reciprocal multiply
  assign t_p19  = {1'b0, total_q} + (TOTAL_W+1)'(19);
  assign t_p9   = {1'b0, total_q} + (TOTAL_W+1)'(9);
  assign prod20 = PROD_W'(t_p19) * PROD_W'(DIV20_MUL);
  assign prod10 = PROD_W'(t_p9) * PROD_W'(DIV10_MUL);
  assign ceil20 = prod20[DIV_SHIFT +: TOTAL_W];
  assign ceil10 = prod10[DIV_SHIFT +: TOTAL_W];

  // used chunks and excess over the 90 percent mark, once above the 95 percent mark
  assign used   = (cnt_q < total_q) ? total_q - cnt_q : '0;
  assign danger = (used > thr95_q) ? used - thr90_q : '0;

  // operation effects on the head and the memory port
  always_comb begin
    total_d       = total_q;
    head_d        = head_q;
    head_run_d    = head_run_q;
    head_link_d   = head_link_q;
    cnt_d         = cnt_q;
    res_granted_d = res_granted_q;
    res_status_d  = res_status_q;
    mem_we        = 1'b0;
    mem_addr      = head_link_q[IW-1:0];
    mem_wdata     = {head_run_q, head_link_q};

    if (cmd_i.exec) begin
      res_granted_d = '0;
      res_status_d  = STATUS_OK;
      if (!is_free) begin
        if (alloc_empty) begin
          res_status_d = STATUS_EMPTY;
        end else begin
          res_granted_d = IDX_W'(head_q);
          cnt_d         = cnt_q - CNT_W'(1);
          if (run_multi) begin
            // run moves to the following chunk
            mem_we      = 1'b1;
            mem_addr    = next_addr;
            mem_wdata   = {head_run_q - RUN_W'(1), head_link_q};
            head_d      = LW'(next_addr);
            head_run_d  = head_run_q - RUN_W'(1);
          end else if (link_valid) begin
            // read the linked entry, captured in the fetch step
            head_d = head_link_q;
          end else begin
            head_d = NO_LINK;
          end
        end
      end else if (!free_ok) begin
        res_status_d = STATUS_RANGE;
      end else begin
        // write the head entry back before it is pushed down
        mem_we    = head_valid;
        mem_addr  = head_addr;
        mem_wdata = {head_run_q, head_link_q};
      end
    end

    if (cmd_i.push) begin
      mem_we      = 1'b1;
      mem_addr    = idx_q;
      mem_wdata   = {RUN_W'(1), head_q};
      head_d      = LW'(idx_q);
      head_run_d  = RUN_W'(1);
      head_link_d = head_q;
      if (cnt_q != '1) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end

    if (cmd_i.fetch) begin
      head_run_d  = rd_q[EW-1 -: RUN_W];
      head_link_d = rd_q[LW-1:0];
    end

    // register write reinitializes the list as one run
    if (cfg_we_i) begin
      total_d     = cfg_total;
      head_d      = '0;
      head_run_d  = cfg_total;
      head_link_d = NO_LINK;
      cnt_d       = cfg_total;
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_W'(RESET_TOTAL);
      thr95_q     <= RESET_THR95;
      thr90_q     <= RESET_THR90;
      head_q      <= '0;
      head_run_q  <= RUN_W'(RESET_TOTAL);
      head_link_q <= NO_LINK;
      cnt_q       <= CNT_W'(RESET_TOTAL);
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      thr95_q     <= total_q - ceil20;
      thr90_q     <= total_q - ceil10;
      head_q      <= head_d;
      head_run_q  <= head_run_d;
      head_link_q <= head_link_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_granted_q <= res_granted_d;
    res_status_q  <= res_status_d;
    if (cmd_i.exec) begin
      idx_q <= IW'(in_chunk_index_i);
    end
    if (cmd_i.load_out) begin
      out_granted_q <= res_granted_q;
      out_status_q  <= res_status_q;
      out_cnt_q     <= cnt_q;
      out_danger_q  <= danger;
    end
  end

  // entry memory, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_addr] <= mem_wdata;
    end
    rd_q <= entry_mem_q[mem_addr];
  end

  assign out_valid_o         = out_valid_q;
  assign out_granted_index_o = out_granted_q;
  assign out_status_o        = out_status_q;
  assign out_free_count_o    = out_cnt_q;
  assign out_danger_excess_o = out_danger_q;

  // checks
  `FCPA_ASSERT_IMP(a_cmd_onehot, 1'b1,
    $onehot0({cmd_i.exec, cmd_i.push, cmd_i.fetch, cmd_i.load_out}),
    "more than one datapath command at once")
  `FCPA_ASSERT_IMP(a_load_slot_free, cmd_i.load_out, !out_valid_q || !out_stall_i,
    "result loaded over a stalled output")
  `FCPA_ASSERT_IMP(a_fetch_after_read, cmd_i.fetch, $past(cmd_i.exec) && head_valid,
    "entry fetch without a preceding link read")
  `FCPA_ASSERT_IMP(a_mem_write_steps, mem_we, cmd_i.exec || cmd_i.push,
    "memory written outside an operation step")
  `FCPA_ASSERT_NXT(a_push_counts, cmd_i.push, cnt_q != '0,
    "free count zero after a push")

endmodule

// ===== hdl/fixed_chunk_pool_allocator.sv =====
// top level of the fixed chunk pool allocator
// steps: an alloc from a run, an alloc with no link left or a rejected op goes from idle to done;
//   a free goes through push and an alloc that follows a link through fetch, as the single-port
//   entry memory needs write-back then push, or read then capture; input stalls outside idle
// a new item is taken while the previous result waits in the output register
// reset (async, active low) restores one run of min(MAX_CHUNKS, 1024) chunks; no memory clear
module fixed_chunk_pool_allocator import fcpa_pkg::*; #(
  parameter int unsigned MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TOTAL_W-1:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                in_opcode_i,
  input  logic [IDX_W-1:0]    in_chunk_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IDX_W-1:0]    out_granted_index_o,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [CNT_W-1:0]    out_free_count_o,
  output logic [TOTAL_W-1:0]  out_danger_excess_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  fcpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // free list datapath
  fcpa_datapath #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_opcode_i         (in_opcode_i),
    .in_chunk_index_i    (in_chunk_index_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .out_granted_index_o (out_granted_index_o),
    .out_status_o        (out_status_o),
    .out_free_count_o    (out_free_count_o),
    .out_danger_excess_o (out_danger_excess_o),
    .cmd_i               (cmd),
    .stat_o              (stat)
  );

endmodule

// ===== tb/sv/fixed_chunk_pool_allocator_tb.sv =====
// testbench for the fixed chunk pool allocator: scoreboard, drivers and test phases
`timescale 1ns / 100ps

module fixed_chunk_pool_allocator_tb;
  import fcpa_pkg::*;

  localparam int unsigned POOL_MAX    = DEF_MAX_CHUNKS;
  localparam int unsigned NO_LINK     = POOL_MAX;
  localparam int unsigned QUIET_LIMIT = 600;

  typedef struct packed {
    logic [IDX_W-1:0]   granted;
    status_e            status;
    logic [CNT_W-1:0]   free_count;
    logic [TOTAL_W-1:0] danger;
  } grant_t;

  // shadow of the free list; predicts one grant per request
  class chunk_pool_scoreboard;
    logic [RUN_W-1:0]   run_len   [POOL_MAX];
    logic [TOTAL_W-1:0] next_head [POOL_MAX];
    logic [TOTAL_W-1:0] head_idx;
    logic [CNT_W-1:0]   free_cnt;
    int unsigned        pool_total;
    grant_t             awaited_grants[$];
    int                 errors;

    function new();
      errors = 0;
      set_total((POOL_MAX < RESET_TOTAL_CAP) ? POOL_MAX : RESET_TOTAL_CAP);
    endfunction

    // register write: clamp, then one run over the whole pool
    function void set_total(int unsigned v);
      if (v < 1) v = 1;
      if (v > POOL_MAX) v = POOL_MAX;
      pool_total   = v;
      head_idx     = '0;
      run_len[0]   = RUN_W'(v);
      next_head[0] = TOTAL_W'(NO_LINK);
      free_cnt     = CNT_W'(v);
    endfunction

    function grant_t note_request(opcode_e op, logic [IDX_W-1:0] idx);
      grant_t             g;
      logic [TOTAL_W-1:0] h;
      logic [TOTAL_W-1:0] nx;
      int unsigned        used;
      g.granted = '0;
      g.status  = STATUS_OK;
      if (op == OP_ALLOC) begin
        if (free_cnt == 0 || head_idx >= POOL_MAX) begin
          g.status = STATUS_EMPTY;
        end else begin
          h         = head_idx;
          g.granted = h[IDX_W-1:0];
          free_cnt  = free_cnt - 1'b1;
          if (run_len[h] > 1) begin
            // run shrinks and moves up one chunk
            nx            = (h + 11'd1 >= POOL_MAX) ? '0 : h + 11'd1;
            run_len[nx]   = run_len[h] - 1'b1;
            next_head[nx] = next_head[h];
            head_idx      = nx;
          end else begin
            head_idx = (next_head[h] < POOL_MAX) ? next_head[h] : TOTAL_W'(NO_LINK);
          end
        end
      end else if (idx >= pool_total) begin
        g.status = STATUS_RANGE;
      end else begin
        // push a run of one, counter saturates
        run_len[idx]   = RUN_W'(1);
        next_head[idx] = head_idx;
        head_idx       = TOTAL_W'(idx);
        if (free_cnt != {CNT_W{1'b1}}) free_cnt = free_cnt + 1'b1;
      end
      g.free_count = free_cnt;
      used = (free_cnt < pool_total) ? pool_total - free_cnt : 0;
      g.danger = (used > pool_total * 95 / 100) ? TOTAL_W'(used - pool_total * 90 / 100) : '0;
      awaited_grants.push_back(g);
      return g;
    endfunction

    function void check_grant(logic [IDX_W-1:0] granted, logic [STATUS_W-1:0] status,
                              logic [CNT_W-1:0] free_count, logic [TOTAL_W-1:0] danger);
      grant_t g;
      if (awaited_grants.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
      end else begin
        g = awaited_grants.pop_front();
        if (granted !== g.granted) begin
          $error("granted_index: expected %0d, actual %0d", g.granted, granted);
          errors++;
        end
        if (status !== g.status) begin
          $error("status: expected %0d, actual %0d", g.status, status);
          errors++;
        end
        if (free_count !== g.free_count) begin
          $error("free_count: expected %0d, actual %0d", g.free_count, free_count);
          errors++;
        end
        if (danger !== g.danger) begin
          $error("danger_excess: expected %0d, actual %0d", g.danger, danger);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk_i               = 1'b0;
  logic                rst_ni              = 1'b0;
  logic                cfg_we_i            = 1'b0;
  logic [TOTAL_W-1:0]  cfg_wdata_i         = '0;
  logic                in_valid_i          = 1'b0;
  logic                in_stall_o;
  logic                in_opcode_i         = 1'b0;
  logic [IDX_W-1:0]    in_chunk_index_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i         = 1'b0;
  logic [IDX_W-1:0]    out_granted_index_o;
  logic [STATUS_W-1:0] out_status_o;
  logic [CNT_W-1:0]    out_free_count_o;
  logic [TOTAL_W-1:0]  out_danger_excess_o;

  chunk_pool_scoreboard sb = new();
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  int in_count    = 0;
  int out_count   = 0;

  always #6 clk_i = ~clk_i;

  fixed_chunk_pool_allocator u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_opcode_i         (in_opcode_i),
    .in_chunk_index_i    (in_chunk_index_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_granted_index_o (out_granted_index_o),
    .out_status_o        (out_status_o),
    .out_free_count_o    (out_free_count_o),
    .out_danger_excess_o (out_danger_excess_o)
  );

  // one request transfer, with a random gap ahead of it
  task automatic send_op(input opcode_e op, input logic [IDX_W-1:0] idx, output grant_t g);
    int gap;
    if (in_count % 32 == 0) in_idle_on = ($urandom_range(0, 3) != 0);
    gap = in_idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_opcode_i      <= op;
    in_chunk_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    g = sb.note_request(op, idx);
    in_count++;
  endtask

  // stop requesting and let every outstanding grant come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.awaited_grants.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [TOTAL_W-1:0] v);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_total(v);
  endtask

  // random phase: fill and drain windows or a free flood, mostly frees of held chunks
  task automatic run_phase(input logic [TOTAL_W-1:0] v, input int n_items, input bit flood);
    logic [IDX_W-1:0] held[$];
    logic [IDX_W-1:0] idx;
    opcode_e          op;
    grant_t           g;
    int unsigned      t;
    int               pct;
    int               r;
    int               pick;
    bit               fill;
    write_total(v);
    t    = sb.pool_total;
    fill = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (flood) begin
        pct = (i < n_items - 40) ? 0 : 50;
      end else begin
        if (i % 64 == 0) fill = $urandom_range(0, 1);
        pct = fill ? 90 : 20;
      end
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < pct) begin
        op  = OP_ALLOC;
        idx = IDX_W'($urandom);
      end else begin
        op = OP_FREE;
        if (held.size() > 0 && r < 80) begin
          pick = $urandom_range(0, held.size() - 1);
          idx  = held[pick];
          held.delete(pick);
        end else if (r < 92 || t >= POOL_MAX) begin
          idx = IDX_W'($urandom_range(0, t - 1));
        end else begin
          idx = IDX_W'($urandom_range(t, POOL_MAX - 1));
        end
      end
      send_op(op, idx, g);
      if (op == OP_ALLOC && g.status == STATUS_OK) held.push_back(g.granted);
    end
  endtask

  // result side: random stall ahead of each result, check on transfer
  initial begin
    int stall_cycles;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (out_count % 32 == 0) out_idle_on = ($urandom_range(0, 3) != 0);
      stall_cycles = out_idle_on ? $urandom_range(0, 11) : 0;
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_grant(out_granted_index_o, out_status_o, out_free_count_o,
                     out_danger_excess_o);
      out_count++;
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    grant_t g;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // full pool after reset: run split, link follow, double free
    send_op(OP_ALLOC, '0, g);
    send_op(OP_ALLOC, '1, g);
    send_op(OP_FREE, IDX_W'(0), g);
    send_op(OP_ALLOC, '0, g);
    send_op(OP_FREE, IDX_W'(POOL_MAX - 1), g);
    send_op(OP_FREE, IDX_W'(POOL_MAX - 1), g);
    send_op(OP_ALLOC, '0, g);
    send_op(OP_ALLOC, '0, g);
    send_op(OP_ALLOC, '0, g);

    // zero total clamps to one chunk: empty pool, range rejects, self link
    write_total('0);
    send_op(OP_ALLOC, '0, g);
    send_op(OP_ALLOC, '0, g);
    send_op(OP_FREE, IDX_W'(1), g);
    send_op(OP_FREE, '1, g);
    send_op(OP_FREE, IDX_W'(0), g);
    send_op(OP_FREE, IDX_W'(0), g);
    send_op(OP_ALLOC, '0, g);
    send_op(OP_ALLOC, '0, g);
    send_op(OP_ALLOC, '0, g);

    // oversize total clamps to the pool maximum
    write_total('1);
    send_op(OP_FREE, '1, g);
    send_op(OP_ALLOC, '1, g);

    run_phase(TOTAL_W'(POOL_MAX + 1), 40, 1'b0);
    run_phase(TOTAL_W'(2), 30, 1'b0);
    run_phase(TOTAL_W'(3), 30, 1'b0);
    run_phase(TOTAL_W'(17), 40, 1'b0);
    run_phase(TOTAL_W'(64), 40, 1'b0);
    run_phase(TOTAL_W'(200), 40, 1'b0);
    run_phase(TOTAL_W'($urandom_range(1, 2047)), 20, 1'b0);
    // free run on the full pool, allocs mixed in only over the last 40 items, drives the counter into saturation
    run_phase(TOTAL_W'(POOL_MAX), 1070, 1'b1);
    run_phase(TOTAL_W'(1), 20, 1'b0);

    drain_results();
    if (sb.errors == 0 && sb.awaited_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
